>>> hw/rtl/nmcs_pkg.sv
// ---------------------------------------------------------------------------
// nmcs_pkg
// Shared types and constants for the nearest mesh cell search block.
// ---------------------------------------------------------------------------
package nmcs_pkg;

    localparam int COORD_W_DEF   = 16;
    localparam int MAX_CELLS_DEF = 65536;

    typedef struct packed {
        logic signed [COORD_W_DEF-1:0] point_x;
        logic signed [COORD_W_DEF-1:0] point_y;
        logic signed [COORD_W_DEF-1:0] vertex_a_x;
        logic signed [COORD_W_DEF-1:0] vertex_a_y;
        logic signed [COORD_W_DEF-1:0] vertex_b_x;
        logic signed [COORD_W_DEF-1:0] vertex_b_y;
        logic signed [COORD_W_DEF-1:0] vertex_c_x;
        logic signed [COORD_W_DEF-1:0] vertex_c_y;
        logic signed [COORD_W_DEF-1:0] vertex_d_x;
        logic signed [COORD_W_DEF-1:0] vertex_d_y;
        logic                          quad_cell;
        logic                          last_cell;
    } nmcs_in_t;

    typedef struct packed {
        logic [15:0] nearest_index;
        logic [32:0] distance_squared;
        logic [16:0] distance;
        logic        inside_hit;
    } nmcs_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_EDGE2,
        ST_SQR,
        ST_DIV,
        ST_EDGE_END,
        ST_INS,
        ST_INS2,
        ST_UPDATE,
        ST_SQRT,
        ST_OUT
    } nmcs_state_t;

endpackage

>>> hw/rtl/nearest_mesh_cell_search.sv
// ---------------------------------------------------------------------------
// nearest_mesh_cell_search
// Streams mesh cells for one query point and reports the nearest cell, its
// squared distance and the floor square root of that distance.
// ---------------------------------------------------------------------------
//  channel | direction | payload     | notes
//  s_      | in        | nmcs_in_t   | one cell per transfer
//  m_      | out       | nmcs_out_t  | one result per last_cell
//
//  a cell is scanned edge by edge; each edge whose nearest point lies on the
//  line adds a squaring step and then one quotient bit a cycle over 70
//  dividend bits on a shared restoring divider, and an inside test may follow
//  edge by edge; a last cell adds a bit-pair square root and an output step.
//  s_ready is low while a cell is processed; a result waiting on m_ holds the
//  block only in its output step.
//  reset is synchronous on aresetn low and clears the search state.
// ---------------------------------------------------------------------------
module nearest_mesh_cell_search
    import nmcs_pkg::*;
#(
    parameter int MAX_CELLS  = MAX_CELLS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  nmcs_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output nmcs_out_t m_data
);

    localparam int COORD_BITS = COORD_W_DEF;
    localparam int CW  = COORD_BITS + 1;          // difference width
    localparam int PW  = 2 * CW + 1;              // products and sums of two
    localparam int QW  = 2 * CW;                  // quotient / distance width
    localparam int NW  = 2 * PW;                  // dividend width
    localparam int DCW = $clog2(NW + 1);
    localparam int CNTW = $clog2(MAX_CELLS + 1);
    localparam logic [QW:0] SB_START = (QW+1)'(1) << (QW - 2 + (QW % 2));

    nmcs_state_t state_reg, state_next;

    // captured cell
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] vx_reg [4];
    logic signed [CW-1:0] vy_reg [4];
    logic quad_reg, last_reg;

    // search state
    logic [QW-1:0]   best_reg;
    logic [15:0]     best_cell_reg;
    logic [CNTW-1:0] count_reg;
    logic            hit_reg;

    // edge loop
    logic [1:0]      e_reg;
    logic [QW-1:0]   min_reg;
    logic signed [PW-1:0] cross_reg, inprod_reg, n2_reg;
    logic            sgn_reg, ins_reg;

    // shared divider / square root unit
    logic [NW-1:0]   dvd_reg;
    logic [PW:0]     rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic [QW-1:0]   sv_reg;
    logic [QW:0]     sr_reg;
    logic [QW:0]     sb_reg;

    nmcs_out_t out_reg;
    logic      m_valid_reg;
    logic      out_fire;

    // vertex selection for the current edge
    logic [1:0] e_last, e_nxt;
    logic signed [CW-1:0] x1, y1, x2, y2, v1x, v1y, v2x, v2y, w1x, w1y;
    logic signed [PW-1:0] cr_c, ip_c, n1_c, n2_c, ne_c;
    logic [PW:0] rem_sh;
    logic [PW:0] rem_sub;
    logic [QW:0] s_try;
    logic edge_end;

    assign e_last = quad_reg ? 2'd3 : 2'd2;
    assign e_nxt  = (e_reg == e_last) ? 2'd0 : e_reg + 2'd1;
    assign edge_end = (e_reg == e_last);

    always_comb begin
        x1  = vx_reg[e_reg];
        y1  = vy_reg[e_reg];
        x2  = vx_reg[e_nxt];
        y2  = vy_reg[e_nxt];
        v1x = px_reg - x1;
        v1y = py_reg - y1;
        v2x = x2 - x1;
        v2y = y2 - y1;
        w1x = px_reg - x2;
        w1y = py_reg - y2;
        // cross = v2x*v1y - v2y*v1x; its magnitude is used by the distance path
        cr_c = PW'(v2x * v1y) - PW'(v2y * v1x);
        ip_c = PW'(v1x * v2x) + PW'(v1y * v2y);
        n1_c = PW'(v1x * v1x) + PW'(v1y * v1y);
        n2_c = PW'(v2x * v2x) + PW'(v2y * v2y);
        ne_c = PW'(w1x * w1x) + PW'(w1y * w1y);
    end

    // one restoring divide step
    assign rem_sh  = {rem_reg[PW-1:0], dvd_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, n2_reg};
    // one square root step
    assign s_try   = sr_reg + sb_reg;

    // output stage loads when empty or draining this cycle
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) state_next = ST_EDGE;
            end
            ST_EDGE: begin
                if (hit_reg || count_reg >= CNTW'(MAX_CELLS))
                    state_next = last_reg ? ST_SQRT : ST_IDLE;
                else
                    state_next = ST_EDGE2;
            end
            ST_EDGE2: begin
                if (ip_c < 0 || n2_c == '0 || ip_c > n2_c)
                    state_next = ST_EDGE_END;
                else
                    state_next = ST_SQR;
            end
            ST_SQR: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dcnt_reg == DCW'(1)) state_next = ST_EDGE_END;
            end
            ST_EDGE_END: begin
                state_next = edge_end ? ST_INS : ST_EDGE2;
            end
            ST_INS: begin
                state_next = (count_reg == '0 || min_reg <= best_reg) ? ST_INS2
                                                                      : ST_UPDATE;
            end
            ST_INS2: begin
                // on-edge point, sign change or last edge ends the scan
                if (cr_c == '0 || edge_end || (e_reg != 2'd0 && sgn_reg != (cr_c > 0)))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = last_reg ? ST_SQRT : ST_IDLE;
            end
            ST_SQRT: begin
                if (sb_reg == (QW+1)'(1)) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '0;
            best_cell_reg <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_fire)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        px_reg    <= CW'(signed'(s_data.point_x[COORD_BITS-1:0]));
                        py_reg    <= CW'(signed'(s_data.point_y[COORD_BITS-1:0]));
                        vx_reg[0] <= CW'(signed'(s_data.vertex_a_x[COORD_BITS-1:0]));
                        vy_reg[0] <= CW'(signed'(s_data.vertex_a_y[COORD_BITS-1:0]));
                        vx_reg[1] <= CW'(signed'(s_data.vertex_b_x[COORD_BITS-1:0]));
                        vy_reg[1] <= CW'(signed'(s_data.vertex_b_y[COORD_BITS-1:0]));
                        vx_reg[2] <= CW'(signed'(s_data.vertex_c_x[COORD_BITS-1:0]));
                        vy_reg[2] <= CW'(signed'(s_data.vertex_c_y[COORD_BITS-1:0]));
                        vx_reg[3] <= CW'(signed'(s_data.vertex_d_x[COORD_BITS-1:0]));
                        vy_reg[3] <= CW'(signed'(s_data.vertex_d_y[COORD_BITS-1:0]));
                        quad_reg  <= s_data.quad_cell;
                        last_reg  <= s_data.last_cell;
                    end
                    e_reg <= 2'd0;
                end
                ST_EDGE: begin
                    e_reg   <= 2'd0;
                    min_reg <= '1;
                    // square root setup for an ignored last cell
                    sv_reg  <= hit_reg ? '0 : best_reg;
                    sr_reg  <= '0;
                    sb_reg  <= SB_START;
                end
                ST_EDGE2: begin
                    // register the edge products, cross kept as magnitude
                    cross_reg  <= (cr_c < 0) ? -cr_c : cr_c;
                    inprod_reg <= ip_c;
                    n2_reg     <= n2_c;
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    dcnt_reg   <= DCW'(NW);
                    // provisional distance: start or end vertex
                    if (ip_c < 0 || n2_c == '0) sv_reg <= QW'(n1_c);
                    else                        sv_reg <= QW'(ne_c);
                end
                ST_SQR: begin
                    dvd_reg <= NW'(cross_reg * cross_reg);
                end
                ST_DIV: begin
                    dvd_reg  <= dvd_reg << 1;
                    dcnt_reg <= dcnt_reg - DCW'(1);
                    if (!rem_sub[PW]) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                end
                ST_EDGE_END: begin
                    // ST_DIV leaves a quotient; otherwise the vertex distance
                    if (!(inprod_reg < 0 || n2_reg == '0 || inprod_reg > n2_reg)) begin
                        if (quo_reg < min_reg) min_reg <= quo_reg;
                    end else if (sv_reg < min_reg) begin
                        min_reg <= sv_reg;
                    end
                    e_reg <= e_nxt;
                end
                ST_INS: begin
                    e_reg   <= 2'd0;
                    ins_reg <= (count_reg == '0 || min_reg <= best_reg);
                    sgn_reg <= 1'b0;
                    cross_reg <= '0;
                end
                ST_INS2: begin
                    // cross sign test per edge, on-edge test ends the scan
                    if (cr_c == '0) begin
                        ins_reg <= (PW'(v2y * v1y) >= 0) && (PW'(v1x * v2x) >= 0)
                                   && (n2_c >= n1_c);
                        e_reg <= e_last;
                    end else begin
                        if (e_reg == 2'd0) sgn_reg <= (cr_c > 0);
                        else if (sgn_reg != (cr_c > 0)) ins_reg <= 1'b0;
                        e_reg <= e_nxt;
                    end
                end
                ST_UPDATE: begin
                    count_reg <= count_reg + CNTW'(1);
                    if (ins_reg) begin
                        hit_reg       <= 1'b1;
                        best_reg      <= '0;
                        best_cell_reg <= 16'(count_reg);
                    end else if (count_reg == '0 || min_reg < best_reg) begin
                        best_reg      <= min_reg;
                        best_cell_reg <= 16'(count_reg);
                    end
                    sv_reg <= ins_reg ? '0 :
                              ((count_reg == '0 || min_reg < best_reg) ? min_reg
                                                                       : best_reg);
                    sr_reg <= '0;
                    sb_reg <= SB_START;
                end
                ST_SQRT: begin
                    if ((QW+1)'(sv_reg) >= s_try) begin
                        sv_reg <= sv_reg - QW'(s_try);
                        sr_reg <= (sr_reg >> 1) + sb_reg;
                    end else begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sb_reg <= sb_reg >> 2;
                end
                ST_OUT: begin
                    if (out_fire) begin
                        out_reg.nearest_index    <= best_cell_reg;
                        out_reg.distance_squared <= hit_reg ? '0 : 33'(best_reg);
                        out_reg.distance         <= 17'(sr_reg);
                        out_reg.inside_hit       <= hit_reg;
                        best_reg      <= '0;
                        best_cell_reg <= '0;
                        count_reg     <= '0;
                        hit_reg       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // the output step always leaves a result on m_
    property p_out_only_last;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid_reg;
    endproperty
    assert property (p_out_only_last) else $error("result not raised");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("accept while busy");

    property p_hit_zero;
        @(posedge aclk) disable iff (!aresetn)
        hit_reg |-> (best_reg == '0);
    endproperty
    assert property (p_hit_zero) else $error("hit with nonzero distance");

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Checks the nearest mesh cell search block: cells of random and directed
// queries go in, each last cell's result is compared with a local model of
// the edge distance, inside test and square root.
// ---------------------------------------------------------------------------
module tb_top;
    import nmcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: search model plus queue of expected results
    class search_scoreboard;
        logic [33:0] best_dsq;
        int unsigned best_idx;
        int unsigned cells_seen;
        bit          hit;
        nmcs_out_t   pending_results[$];
        int          errors;
        int          results_seen;
        int          hits_seen;

        function new();
            errors = 0;
            results_seen = 0;
            hits_seen = 0;
            restart();
        endfunction

        function void restart();
            best_dsq = 0;
            best_idx = 0;
            cells_seen = 0;
            hit = 0;
        endfunction

        // floor(a*a / d), exact on wide vectors
        function logic [63:0] sq_over(logic [63:0] a, logic [63:0] d);
            logic [127:0] num;
            num = a * a;
            num = num / d;
            return num[63:0];
        endfunction

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [63:0] seg_dist(longint px, longint py, longint x1, longint y1,
                                       longint x2, longint y2);
            longint ax, ay, ex, ey, proj, cr, n1, n2;
            ax = px - x1;
            ay = py - y1;
            ex = x2 - x1;
            ey = y2 - y1;
            proj = ax * ex + ay * ey;
            n1 = ax * ax + ay * ay;
            n2 = ex * ex + ey * ey;
            if (proj < 0 || n2 == 0) return n1;
            if (proj <= n2) begin
                cr = ax * ey - ay * ex;
                if (cr < 0) cr = -cr;
                return sq_over(cr, n2);
            end
            ax = px - x2;
            ay = py - y2;
            return ax * ax + ay * ay;
        endfunction

        function bit point_in_cell(longint px, longint py, longint vx[4], longint vy[4],
                                   int n);
            int j;
            int sgn;
            longint ax, ay, ex, ey, op, nd;
            sgn = 0;
            for (int i = 0; i < n; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                ax = px - vx[i];
                ay = py - vy[i];
                ex = vx[j] - vx[i];
                ey = vy[j] - vy[i];
                op = ex * ay - ey * ax;
                if (op == 0) begin
                    nd = (ex * ex + ey * ey) - (ax * ax + ay * ay);
                    return (ey * ay >= 0 && ax * ex >= 0 && nd >= 0);
                end
                if (i == 0) sgn = op > 0 ? 1 : -1;
                if ((sgn > 0 && op < 0) || (sgn < 0 && op > 0)) return 0;
            end
            return 1;
        endfunction

        // note an accepted cell
        function void note_cell(nmcs_in_t c);
            longint px, py;
            longint vx[4];
            longint vy[4];
            logic [63:0] m, d, dd;
            int n;
            nmcs_out_t r;
            px = longint'(c.point_x);
            py = longint'(c.point_y);
            vx[0] = longint'(c.vertex_a_x); vy[0] = longint'(c.vertex_a_y);
            vx[1] = longint'(c.vertex_b_x); vy[1] = longint'(c.vertex_b_y);
            vx[2] = longint'(c.vertex_c_x); vy[2] = longint'(c.vertex_c_y);
            vx[3] = longint'(c.vertex_d_x); vy[3] = longint'(c.vertex_d_y);
            n = c.quad_cell ? 4 : 3;
            if (!hit && cells_seen < MAX_CELLS_DEF) begin
                m = seg_dist(px, py, vx[0], vy[0], vx[1], vy[1]);
                for (int i = 1; i < n; i++) begin
                    d = seg_dist(px, py, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
                    if (d < m) m = d;
                end
                if (cells_seen == 0 || m <= best_dsq) begin
                    if (point_in_cell(px, py, vx, vy, n)) begin
                        hit = 1;
                        best_dsq = 0;
                        best_idx = cells_seen;
                    end else if (cells_seen == 0 || m < best_dsq) begin
                        best_dsq = 34'(m);
                        best_idx = cells_seen;
                    end
                end
                cells_seen++;
            end
            if (c.last_cell) begin
                dd = hit ? 64'd0 : 64'(best_dsq);
                r.nearest_index = best_idx[15:0];
                r.distance_squared = dd[32:0];
                r.distance = 17'(root_floor(dd));
                r.inside_hit = hit;
                pending_results = {pending_results, r};
                restart();
            end
        endfunction

        // compare a result transfer with the oldest expectation
        function void check_result(nmcs_out_t got);
            nmcs_out_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (want.inside_hit) hits_seen++;
            if (got.nearest_index !== want.nearest_index) begin
                $error("nearest_index exp %0d got %0d", want.nearest_index, got.nearest_index);
                errors++;
            end
            if (got.distance_squared !== want.distance_squared) begin
                $error("distance_squared exp %0d got %0d", want.distance_squared,
                       got.distance_squared);
                errors++;
            end
            if (got.distance !== want.distance) begin
                $error("distance exp %0d got %0d", want.distance, got.distance);
                errors++;
            end
            if (got.inside_hit !== want.inside_hit) begin
                $error("inside_hit exp %0d got %0d", want.inside_hit, got.inside_hit);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    nmcs_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    nmcs_out_t m_data;

    search_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    longint cycle_count = 0;
    int  cells_sent = 0;

    nearest_mesh_cell_search u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("[nearest_mesh_cell_search] ERROR");
            $finish;
        end
    end

    // result side: random stalls, long hold when requested
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one cell and wait for its transfer
    task automatic send_cell(nmcs_in_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_cell(c);
        cells_sent++;
    endtask

    function automatic logic [15:0] rnd_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    function automatic nmcs_in_t mk_cell(int span, bit quad, bit last);
        nmcs_in_t c;
        c.point_x = rnd_coord(span);    c.point_y = rnd_coord(span);
        c.vertex_a_x = rnd_coord(span); c.vertex_a_y = rnd_coord(span);
        c.vertex_b_x = rnd_coord(span); c.vertex_b_y = rnd_coord(span);
        c.vertex_c_x = rnd_coord(span); c.vertex_c_y = rnd_coord(span);
        c.vertex_d_x = rnd_coord(span); c.vertex_d_y = rnd_coord(span);
        c.quad_cell = quad;
        c.last_cell = last;
        return c;
    endfunction

    function automatic nmcs_in_t mk_exact(int px, int py, int ax, int ay, int bx, int by,
                                         int cx, int cy, int dx, int dy, bit quad, bit last);
        nmcs_in_t c;
        c.point_x = 16'(px); c.point_y = 16'(py);
        c.vertex_a_x = 16'(ax); c.vertex_a_y = 16'(ay);
        c.vertex_b_x = 16'(bx); c.vertex_b_y = 16'(by);
        c.vertex_c_x = 16'(cx); c.vertex_c_y = 16'(cy);
        c.vertex_d_x = 16'(dx); c.vertex_d_y = 16'(dy);
        c.quad_cell = quad;
        c.last_cell = last;
        return c;
    endfunction

    task automatic drain();
        s_valid <= 0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // a query of random cells, with coordinates drawn from spans of varied size
    task automatic random_query(int ncells);
        int span;
        nmcs_in_t c;
        for (int i = 0; i < ncells; i++) begin
            case ($urandom_range(3))
                0: span = 0;
                1: span = 32;
                2: span = 2000;
                default: span = 300;
            endcase
            c = mk_cell(span, 1'($urandom_range(1)), i == ncells - 1);
            send_cell(c);
        end
    endtask

    initial begin
        int limit;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, inside, on edge, on vertex, degenerate, ties
        send_cell(mk_exact(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767,
                           0, 0, 0, 1));
        send_cell(mk_exact(32767, 32767, -32768, -32768, -32768, -32767, -32767, -32768,
                           0, 0, 0, 1));
        send_cell(mk_exact(1, 1, 0, 0, 10, 0, 0, 10, 0, 0, 0, 1));
        send_cell(mk_exact(5, 0, 0, 0, 10, 0, 0, 10, 0, 0, 0, 1));
        send_cell(mk_exact(0, 0, 0, 0, 10, 0, 0, 10, 0, 0, 0, 1));
        send_cell(mk_exact(3, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_cell(mk_exact(20, 20, 0, 0, 10, 0, 10, 10, 0, 10, 1, 0));
        send_cell(mk_exact(20, 20, 0, 0, 10, 0, 10, 10, 0, 10, 1, 0));
        send_cell(mk_exact(5, 5, 0, 0, 10, 0, 10, 10, 0, 10, 1, 0));
        send_cell(mk_exact(5, 5, 100, 100, 110, 100, 100, 110, 0, 0, 0, 1));
        send_cell(mk_exact(-7, 3, -20, 0, 20, 0, 20, 30, -20, 30, 1, 1));
        send_cell(mk_exact(50, -3, 0, 0, 10, 0, 5, 9, 0, 0, 0, 0));
        send_cell(mk_exact(50, -3, 0, 0, 30, 0, 5, 9, 0, 0, 0, 1));
        send_cell(mk_exact(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768,
                           32767, 0, 1, 1));
        drain();

        // random queries under the three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 19 : (phase == 1 ? 59 : 0);
            recv_idle_pct = phase == 0 ? 59 : (phase == 1 ? 19 : 0);
            limit = cells_sent + 300;
            while (cells_sent < limit) random_query($urandom_range(1, 5));
            if (phase == 1) begin
                // long receiver hold while cells keep coming
                hold_cycles = 600;
                random_query(4);
                random_query(3);
            end
            drain();
        end

        // a few longer queries
        for (int q = 0; q < 3; q++) random_query($urandom_range(10, 20));
        drain();

        $display("sent %0d cells, checked %0d results, %0d of them inside hits",
                 cells_sent, board.results_seen, board.hits_seen);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("[nearest_mesh_cell_search] OK");
        end else begin
            $display("[nearest_mesh_cell_search] ERROR");
        end
        $finish;
    end
endmodule
